[rtl/orthogonal_connector_router_macros.svh]
// Assertion macros for the orthogonal connector router checker.
// No dependencies; included by the checker file only.
`ifndef ORTHOGONAL_CONNECTOR_ROUTER_MACROS_SVH
`define ORTHOGONAL_CONNECTOR_ROUTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define OCR_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ocr assertion failed");

// Next-cycle implication, disabled during reset.
`define OCR_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ocr assertion failed");

// Next-cycle implication that also holds across reset.
`define OCR_ASSERT_RST(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ocr assertion failed");

`endif

[rtl/ocr_pkg.sv]
// Shared types, constants and helpers for the orthogonal connector router.
// No dependencies; imported by every module of the block.
package ocr_pkg;

  localparam int COORD_BITS   = 16;
  localparam int CFG_BITS     = 12;
  localparam int STYLE_BITS   = 3;
  localparam int REG_IDX_BITS = 2;
  localparam int MAX_POINTS   = 5;
  localparam int CNT_BITS     = $clog2(MAX_POINTS + 1);
  localparam int IDX_BITS     = $clog2(MAX_POINTS);
  // loop offsets reach 2*(2^CFG_BITS-1); keep headroom for sign and carry
  localparam int WIDE_BITS    = ((COORD_BITS > CFG_BITS + 2) ? COORD_BITS : CFG_BITS + 2) + 2;

  localparam logic [STYLE_BITS-1:0] STYLE_STRAIGHT = 3'd0;
  localparam logic [STYLE_BITS-1:0] STYLE_HV       = 3'd1;
  localparam logic [STYLE_BITS-1:0] STYLE_VH       = 3'd2;
  localparam logic [STYLE_BITS-1:0] STYLE_HVH      = 3'd3;
  localparam logic [STYLE_BITS-1:0] STYLE_VHV      = 3'd4;
  localparam logic [STYLE_BITS-1:0] STYLE_AUTO     = 3'd5;

  localparam logic [REG_IDX_BITS-1:0] REG_SEG_MIN     = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_LOOP_WIDTH  = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_LOOP_HEIGHT = 2'd2;

  localparam int ROUTE_BITS = 3;
  localparam logic [ROUTE_BITS-1:0] ROUTE_STRAIGHT  = 3'd0;
  localparam logic [ROUTE_BITS-1:0] ROUTE_HV        = 3'd1;
  localparam logic [ROUTE_BITS-1:0] ROUTE_VH        = 3'd2;
  localparam logic [ROUTE_BITS-1:0] ROUTE_HVH       = 3'd3;
  localparam logic [ROUTE_BITS-1:0] ROUTE_HVH_SHORT = 3'd4;
  localparam logic [ROUTE_BITS-1:0] ROUTE_VHV       = 3'd5;
  localparam logic [ROUTE_BITS-1:0] ROUTE_VHV_SHORT = 3'd6;
  localparam logic [ROUTE_BITS-1:0] ROUTE_LOOP      = 3'd7;

  typedef logic signed [COORD_BITS-1:0] coord_t;
  typedef logic signed [WIDE_BITS-1:0]  wide_t;
  typedef logic [CFG_BITS-1:0]          cfg_t;
  typedef logic [STYLE_BITS-1:0]        style_t;

  localparam wide_t WIDE_CMAX = wide_t'((64'sd1 <<< (COORD_BITS - 1)) - 64'sd1);
  localparam wide_t WIDE_CMIN = -WIDE_CMAX - wide_t'(1);

  typedef struct packed {
    coord_t start_x;
    coord_t start_y;
    coord_t end_x;
    coord_t end_y;
    style_t route_style;
  } in_t;

  typedef struct packed {
    coord_t point_x;
    coord_t point_y;
    logic   last_point;
  } out_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
  } point_t;

  typedef struct packed {
    point_t [MAX_POINTS-1:0] pts;
    logic [CNT_BITS-1:0]     count;
  } route_t;

  function automatic wide_t widen(input coord_t c);
    return wide_t'(c);
  endfunction

  function automatic wide_t widen_cfg(input cfg_t c);
    return wide_t'(c);
  endfunction

  function automatic coord_t sat(input wide_t v);
    if (v > WIDE_CMAX) begin
      return coord_t'(WIDE_CMAX);
    end else if (v < WIDE_CMIN) begin
      return coord_t'(WIDE_CMIN);
    end
    return coord_t'(v);
  endfunction

endpackage

[rtl/ocr_serializer.sv]
// Route buffer and output register: sends the points of one route, one beat
// per cycle while rsp_stall is low. Depends on ocr_pkg.
module ocr_serializer import ocr_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   load_valid,
  output logic   load_ready,
  input  route_t route,
  output logic   rsp_valid,
  input  logic   rsp_stall,
  output out_t   rsp
);

  route_t              held;
  logic                busy;
  logic [IDX_BITS-1:0] idx;
  logic                take;
  logic                is_last;
  logic                emit;
  point_t              cur;

  always_comb begin
    take       = !rsp_valid || !rsp_stall;
    is_last    = (CNT_BITS'(idx) + CNT_BITS'(1)) == held.count;
    emit       = busy && take;
    load_ready = !busy || (take && is_last);
    cur        = held.pts[idx];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      rsp_valid <= 1'b0;
    end else begin
      if (take) begin
        rsp_valid <= busy;
      end
      if (load_valid && load_ready) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (emit) begin
        if (is_last) begin
          busy <= 1'b0;
        end else begin
          idx <= idx + IDX_BITS'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load_valid && load_ready) begin
      held <= route;
    end
    if (emit) begin
      rsp.point_x    <= cur.x;
      rsp.point_y    <= cur.y;
      rsp.last_point <= is_last;
    end
  end

endmodule

[rtl/orthogonal_connector_router.sv]
// Orthogonal connector router top level: config registers, span and offset
// pipeline, route selection. Depends on ocr_pkg and ocr_serializer.
//
// Usage:
//   req channel (req_valid/req_stall/req) takes one connector per beat: start
//   point, end point and route style. rsp channel (rsp_valid/rsp_stall/rsp)
//   returns the route's points in order, last_point set on the final one.
//   cfg_write/cfg_index/cfg_data write the shortest segment length, loop_width
//   and loop_height; write only while no route is in flight. Index 3 is ignored.
//   The first point of a route reaches rsp through the stage 1 and stage 2
//   registers, the point buffer in the serializer and its output register. A
//   route has 2 to 5 points and leaves at one point per cycle while rsp_stall
//   is low; the point buffer sets the sustained rate. Requests are taken every
//   cycle until the two pipeline stages ahead of the buffer are full.
//   Reset: config returns to 10/40/40, the pipeline empties, rsp_valid drops.
//   rsp_stall holds the current point; the stall backs up stage by stage and
//   raises req_stall once every stage holds an item. Nothing is lost.
module orthogonal_connector_router import ocr_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    req_valid,
  output logic                    req_stall,
  input  in_t                     req,
  output logic                    rsp_valid,
  input  logic                    rsp_stall,
  output out_t                    rsp,
  input  logic                    cfg_write,
  input  logic [REG_IDX_BITS-1:0] cfg_index,
  input  cfg_t                    cfg_data
);

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    style_t style;
    logic   same;
    wide_t  dx;
    wide_t  dy;
    coord_t midx;
    coord_t midy;
    wide_t  x1;
    wide_t  x2;
    wide_t  x3;
    wide_t  y2;
    wide_t  y3;
  } s1_t;

  typedef struct packed {
    coord_t ax;
    coord_t ay;
    coord_t bx;
    coord_t by;
    style_t style;
    logic   same;
    coord_t midx;
    coord_t midy;
    logic   hv_ok;
    logic   hvh_ok;
    logic   hvh_short;
    logic   vhv_ok;
    logic   vhv_short;
    coord_t x1;
    coord_t x2;
    coord_t x3;
    coord_t y2;
    coord_t y3;
  } s2_t;

  cfg_t seg_min;
  cfg_t loop_width;
  cfg_t loop_height;

  s1_t  s1, s1_next;
  s2_t  s2, s2_next;
  logic s1_valid, s2_valid;
  logic s1_ready, s2_ready;
  logic ser_ready;

  logic signed [COORD_BITS:0] sumx, sumy;
  wide_t  wv, hh, absdx, absdy, m, m2;
  logic [ROUTE_BITS-1:0] code;
  route_t route_next;
  point_t pa, pb;

  always_ff @(posedge clk) begin
    if (rst) begin
      seg_min     <= cfg_t'(10);
      loop_width  <= cfg_t'(40);
      loop_height <= cfg_t'(40);
    end else if (cfg_write) begin
      case (cfg_index)
        REG_SEG_MIN:     seg_min     <= cfg_data;
        REG_LOOP_WIDTH:  loop_width  <= cfg_data;
        REG_LOOP_HEIGHT: loop_height <= cfg_data;
        default: ;
      endcase
    end
  end

  // stage 1: differences, midpoints, raw loop coordinates
  always_comb begin
    sumx = {req.start_x[COORD_BITS-1], req.start_x} + {req.end_x[COORD_BITS-1], req.end_x};
    sumy = {req.start_y[COORD_BITS-1], req.start_y} + {req.end_y[COORD_BITS-1], req.end_y};
    wv   = widen_cfg(loop_width);
    hh   = widen_cfg(loop_height);
    s1_next.ax    = req.start_x;
    s1_next.ay    = req.start_y;
    s1_next.bx    = req.end_x;
    s1_next.by    = req.end_y;
    s1_next.style = req.route_style;
    s1_next.same  = (req.start_x == req.end_x) && (req.start_y == req.end_y);
    s1_next.dx    = widen(req.end_x) - widen(req.start_x);
    s1_next.dy    = widen(req.end_y) - widen(req.start_y);
    s1_next.midx  = sumx[COORD_BITS:1];
    s1_next.midy  = sumy[COORD_BITS:1];
    s1_next.x1    = widen(req.start_x) + ((wv + (wv <<< 1)) >>> 2);
    s1_next.x2    = widen(req.start_x) + (wv <<< 1);
    s1_next.x3    = widen(req.start_x) + wv;
    s1_next.y2    = widen(req.start_y) + hh;
    s1_next.y3    = widen(req.start_y) - (hh >>> 2);
  end

  // stage 2: span tests, saturation of loop coordinates
  always_comb begin
    absdx = s1.dx[WIDE_BITS-1] ? -s1.dx : s1.dx;
    absdy = s1.dy[WIDE_BITS-1] ? -s1.dy : s1.dy;
    m     = widen_cfg(seg_min);
    m2    = m <<< 1;
    s2_next.ax        = s1.ax;
    s2_next.ay        = s1.ay;
    s2_next.bx        = s1.bx;
    s2_next.by        = s1.by;
    s2_next.style     = s1.style;
    s2_next.same      = s1.same;
    s2_next.midx      = s1.midx;
    s2_next.midy      = s1.midy;
    s2_next.hv_ok     = (absdx >= m) && (absdy >= m);
    s2_next.hvh_ok    = absdx >= m2;
    s2_next.hvh_short = absdy <= m;
    s2_next.vhv_ok    = absdy >= m2;
    s2_next.vhv_short = absdx <= m;
    s2_next.x1        = sat(s1.x1);
    s2_next.x2        = sat(s1.x2);
    s2_next.x3        = sat(s1.x3);
    s2_next.y2        = sat(s1.y2);
    s2_next.y3        = sat(s1.y3);
  end

  // stage 3: pick the route, with fallbacks, and lay out its points
  always_comb begin
    case (s2.style)
      STYLE_STRAIGHT: code = ROUTE_STRAIGHT;
      STYLE_HV: code = s2.hv_ok ? ROUTE_HV : (s2.same ? ROUTE_LOOP : ROUTE_STRAIGHT);
      STYLE_VH: code = s2.hv_ok ? ROUTE_VH : (s2.same ? ROUTE_LOOP : ROUTE_STRAIGHT);
      STYLE_HVH: begin
        if (s2.hvh_ok) begin
          code = s2.hvh_short ? ROUTE_HVH_SHORT : ROUTE_HVH;
        end else if (s2.same) begin
          code = ROUTE_LOOP;
        end else if (s2.vhv_ok) begin
          code = s2.vhv_short ? ROUTE_VHV_SHORT : ROUTE_VHV;
        end else begin
          code = ROUTE_STRAIGHT;
        end
      end
      STYLE_VHV: begin
        if (s2.vhv_ok) begin
          code = s2.vhv_short ? ROUTE_VHV_SHORT : ROUTE_VHV;
        end else if (s2.same) begin
          code = ROUTE_LOOP;
        end else if (s2.hvh_ok) begin
          code = s2.hvh_short ? ROUTE_HVH_SHORT : ROUTE_HVH;
        end else begin
          code = ROUTE_STRAIGHT;
        end
      end
      default: code = s2.same ? ROUTE_LOOP : ROUTE_STRAIGHT;
    endcase

    pa = '{x: s2.ax, y: s2.ay};
    pb = '{x: s2.bx, y: s2.by};
    route_next.pts   = {MAX_POINTS{pb}};
    route_next.count = CNT_BITS'(2);
    case (code)
      ROUTE_HV: begin
        route_next.pts[0] = pa;
        route_next.pts[1] = '{x: s2.bx, y: s2.ay};
        route_next.pts[2] = pb;
        route_next.count  = CNT_BITS'(3);
      end
      ROUTE_VH: begin
        route_next.pts[0] = pa;
        route_next.pts[1] = '{x: s2.ax, y: s2.by};
        route_next.pts[2] = pb;
        route_next.count  = CNT_BITS'(3);
      end
      ROUTE_HVH: begin
        route_next.pts[0] = pa;
        route_next.pts[1] = '{x: s2.midx, y: s2.ay};
        route_next.pts[2] = '{x: s2.midx, y: s2.by};
        route_next.pts[3] = pb;
        route_next.count  = CNT_BITS'(4);
      end
      ROUTE_HVH_SHORT: begin
        route_next.pts[0] = '{x: s2.ax, y: s2.by};
        route_next.pts[1] = pb;
      end
      ROUTE_VHV: begin
        route_next.pts[0] = pa;
        route_next.pts[1] = '{x: s2.ax, y: s2.midy};
        route_next.pts[2] = '{x: s2.bx, y: s2.midy};
        route_next.pts[3] = pb;
        route_next.count  = CNT_BITS'(4);
      end
      ROUTE_VHV_SHORT: begin
        route_next.pts[0] = '{x: s2.bx, y: s2.ay};
        route_next.pts[1] = pb;
      end
      ROUTE_LOOP: begin
        route_next.pts[0] = '{x: s2.x1, y: s2.ay};
        route_next.pts[1] = '{x: s2.x1, y: s2.y2};
        route_next.pts[2] = '{x: s2.x2, y: s2.y2};
        route_next.pts[3] = '{x: s2.x2, y: s2.y3};
        route_next.pts[4] = '{x: s2.x3, y: s2.y3};
        route_next.count  = CNT_BITS'(5);
      end
      default: begin
        route_next.pts[0] = pa;
        route_next.pts[1] = pb;
      end
    endcase
  end

  always_comb begin
    s2_ready  = !s2_valid || ser_ready;
    s1_ready  = !s1_valid || s2_ready;
    req_stall = !s1_ready;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_valid <= req_valid;
      end
      if (s2_ready) begin
        s2_valid <= s1_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_ready && req_valid) begin
      s1 <= s1_next;
    end
    if (s2_ready && s1_valid) begin
      s2 <= s2_next;
    end
  end

  ocr_serializer u_serializer (
    .clk        (clk),
    .rst        (rst),
    .load_valid (s2_valid),
    .load_ready (ser_ready),
    .route      (route_next),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .rsp        (rsp)
  );

endmodule

[rtl/ocr_checker.sv]
// Port-level checks for the orthogonal connector router, bound to the top.
// Depends on ocr_pkg and orthogonal_connector_router_macros.svh.
`include "orthogonal_connector_router_macros.svh"

module ocr_checker import ocr_pkg::*; (
  input logic clk,
  input logic rst,
  input logic req_stall,
  input logic rsp_valid,
  input logic rsp_stall,
  input out_t rsp
);

  logic [CNT_BITS-1:0] run;
  logic                rsp_beat;
  logic                mid_beat;
  logic                run_ok;

  assign rsp_beat = rsp_valid && !rsp_stall;
  assign mid_beat = rsp_beat && !rsp.last_point;
  assign run_ok   = run < CNT_BITS'(MAX_POINTS - 1);

  // points since the last route end
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= '0;
    end else if (rsp_beat) begin
      run <= rsp.last_point ? '0 : run + CNT_BITS'(1);
    end
  end

  `OCR_ASSERT_RST(a_rsp_idle_after_reset, clk, rst, !rsp_valid)
  `OCR_ASSERT_RST(a_req_open_after_reset, clk, rst, !req_stall)
  `OCR_ASSERT_NEXT(a_rsp_hold, clk, rst, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))
  `OCR_ASSERT_NOW(a_route_len, clk, rst, mid_beat, run_ok)

endmodule

bind orthogonal_connector_router ocr_checker u_checker (.*);

[bench/orthogonal_connector_router_test.sv]
// Self-checking bench for orthogonal_connector_router: directed and random connectors,
// route points predicted in-bench and compared beat by beat. Depends on ocr_pkg and
// the router RTL.
module orthogonal_connector_router_test;
  import ocr_pkg::*;

  localparam int HOLD_CYCLES   = 150;
  localparam int IDLE_LIMIT    = 2000;
  localparam int SETTLE_CYCLES = 20;
  localparam int PHASE_ROUTES  = 70;
  localparam int PHASES        = 7;

  localparam longint CMAX = (64'sd1 <<< (COORD_BITS - 1)) - 64'sd1;
  localparam longint CMIN = -CMAX - 64'sd1;

  localparam style_t STYLE_SPARE6 = 3'd6;
  localparam style_t STYLE_SPARE7 = 3'd7;
  localparam logic [REG_IDX_BITS-1:0] REG_SPARE = 2'd3;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid = 1'b0;
  logic req_stall;
  in_t req = '0;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  out_t rsp;
  logic cfg_write = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_index = REG_SEG_MIN;
  cfg_t cfg_data = '0;

  // register mirror, reset values
  cfg_t min_seg = 12'd10;
  cfg_t loop_w = 12'd40;
  cfg_t loop_h = 12'd40;

  in_t queued_routes[$];
  out_t pending_points[$];
  out_t route_pts[$];

  int routes_queued = 0;
  int routes_taken = 0;
  int seen_taken = 0;
  int mismatches = 0;
  int idle_cycles = 0;
  int send_gap = 0;
  int stall_left = 0;
  int hold_requests = 0;
  int holds_done = 0;
  bit send_calm = 1'b0;
  bit recv_calm = 1'b0;

  orthogonal_connector_router dut (
    .clk(clk),
    .rst(rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req(req),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp(rsp),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic coord_t to_coord(longint v);
    if (v > CMAX) begin
      v = CMAX;
    end else if (v < CMIN) begin
      v = CMIN;
    end
    return coord_t'(v);
  endfunction

  function automatic longint span(longint a, longint b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic void add_pt(longint x, longint y);
    out_t p;
    p.point_x = to_coord(x);
    p.point_y = to_coord(y);
    p.last_point = 1'b0;
    route_pts.insert(route_pts.size(), p);
  endfunction

  // Builds a bent route into route_pts; 0 when the spans are too short.
  function automatic bit plan_bent(style_t st, longint ax, longint ay, longint bx, longint by);
    longint m;
    longint mid;
    m = longint'(min_seg);
    route_pts.delete();
    if (st == STYLE_HV || st == STYLE_VH) begin
      if (span(ax, bx) < m || span(ay, by) < m) begin
        return 1'b0;
      end
      add_pt(ax, ay);
      if (st == STYLE_HV) begin
        add_pt(bx, ay);
      end else begin
        add_pt(ax, by);
      end
      add_pt(bx, by);
      return 1'b1;
    end
    if (st == STYLE_HVH) begin
      if (span(ax, bx) < 2 * m) begin
        return 1'b0;
      end
      if (span(ay, by) <= m) begin
        add_pt(ax, by);
        add_pt(bx, by);
        return 1'b1;
      end
      mid = (ax + bx) >>> 1;
      add_pt(ax, ay);
      add_pt(mid, ay);
      add_pt(mid, by);
      add_pt(bx, by);
      return 1'b1;
    end
    if (st == STYLE_VHV) begin
      if (span(ay, by) < 2 * m) begin
        return 1'b0;
      end
      if (span(ax, bx) <= m) begin
        add_pt(bx, ay);
        add_pt(bx, by);
        return 1'b1;
      end
      mid = (ay + by) >>> 1;
      add_pt(ax, ay);
      add_pt(ax, mid);
      add_pt(bx, mid);
      add_pt(bx, by);
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic void predict_route(in_t r);
    longint ax, ay, bx, by, w, h;
    style_t st, alt;
    bit bent, done;
    ax = longint'($signed(r.start_x));
    ay = longint'($signed(r.start_y));
    bx = longint'($signed(r.end_x));
    by = longint'($signed(r.end_y));
    w = longint'(loop_w);
    h = longint'(loop_h);
    st = r.route_style;
    bent = (st >= STYLE_HV && st <= STYLE_VHV);
    done = 1'b0;
    case (st)
      STYLE_HV: alt = STYLE_VH;
      STYLE_VH: alt = STYLE_HV;
      STYLE_HVH: alt = STYLE_VHV;
      default: alt = STYLE_HVH;
    endcase
    if (st != STYLE_STRAIGHT) begin
      if (bent) begin
        done = plan_bent(st, ax, ay, bx, by);
      end
      if (!done && ax == bx && ay == by) begin
        route_pts.delete();
        add_pt(ax + (3 * w) / 4, ay);
        add_pt(ax + (3 * w) / 4, ay + h);
        add_pt(ax + 2 * w, ay + h);
        add_pt(ax + 2 * w, ay - h / 4);
        add_pt(ax + w, ay - h / 4);
        done = 1'b1;
      end else if (!done && bent) begin
        done = plan_bent(alt, ax, ay, bx, by);
      end
    end
    if (!done) begin
      route_pts.delete();
      add_pt(ax, ay);
      add_pt(bx, by);
    end
    route_pts[route_pts.size() - 1].last_point = 1'b1;
    foreach (route_pts[i]) begin
      pending_points.insert(pending_points.size(), route_pts[i]);
    end
  endfunction

  task automatic report_mismatch(string what);
    $display("[%0t] point mismatch: %s", $time, what);
    mismatches++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) begin
      return 0;
    end else if (r < 92) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic longint near_span();
    longint m, d;
    m = longint'(min_seg);
    case ($urandom_range(0, 7))
      0: d = 0;
      1: d = m - 1;
      2: d = m;
      3: d = m + 1;
      4: d = 2 * m - 1;
      5: d = 2 * m;
      6: d = 2 * m + 1;
      default: d = $urandom_range(0, int'(3 * m + 8));
    endcase
    if (d < 0) begin
      d = 0;
    end
    return $urandom_range(0, 1) ? -d : d;
  endfunction

  function automatic longint edge_coord();
    case ($urandom_range(0, 5))
      0: return CMIN;
      1: return CMIN + 1;
      2: return CMAX;
      3: return CMAX - 1;
      4: return 0;
      default: return -1;
    endcase
  endfunction

  function automatic longint any_coord();
    return longint'($signed(coord_t'($urandom)));
  endfunction

  function automatic void add_route(longint x0, longint y0, longint x1, longint y1, style_t st);
    in_t r;
    r.start_x = to_coord(x0);
    r.start_y = to_coord(y0);
    r.end_x = to_coord(x1);
    r.end_y = to_coord(y1);
    r.route_style = st;
    queued_routes.insert(queued_routes.size(), r);
    routes_queued++;
  endfunction

  function automatic void add_random_route();
    longint ax, ay, bx, by;
    int kind;
    style_t st;
    kind = $urandom_range(0, 99);
    ax = any_coord();
    ay = any_coord();
    if (kind < 40) begin
      bx = ax + near_span();
      by = ay + near_span();
    end else if (kind < 55) begin
      if ($urandom_range(0, 1)) begin
        ax = edge_coord();
        ay = edge_coord();
      end
      bx = ax;
      by = ay;
    end else if (kind < 70) begin
      ax = edge_coord();
      ay = edge_coord();
      bx = edge_coord();
      by = edge_coord();
    end else begin
      bx = any_coord();
      by = any_coord();
    end
    if ($urandom_range(0, 3) == 0) begin
      st = style_t'($urandom_range(0, 7));
    end else begin
      st = style_t'($urandom_range(1, 5));
    end
    add_route(ax, ay, bx, by, st);
  endfunction

  task automatic write_reg(logic [REG_IDX_BITS-1:0] idx, cfg_t val);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_write <= 1'b0;
    case (idx)
      REG_SEG_MIN: min_seg = val;
      REG_LOOP_WIDTH: loop_w = val;
      REG_LOOP_HEIGHT: loop_h = val;
      default: ;
    endcase
  endtask

  task automatic configure(cfg_t m, cfg_t w, cfg_t h);
    write_reg(REG_SEG_MIN, m);
    write_reg(REG_LOOP_WIDTH, w);
    write_reg(REG_LOOP_HEIGHT, h);
  endtask

  task automatic drain();
    while (routes_taken != routes_queued || pending_points.size() != 0) begin
      @(negedge clk);
    end
  endtask

  // request driver
  always @(negedge clk) begin
    if (!rst && !(req_valid && routes_taken == seen_taken)) begin
      seen_taken = routes_taken;
      if (send_gap > 0) begin
        send_gap--;
        req_valid <= 1'b0;
      end else if (queued_routes.size() != 0) begin
        req <= queued_routes.pop_front();
        req_valid <= 1'b1;
        send_gap = send_calm ? 0 : gap_len();
      end else begin
        req_valid <= 1'b0;
      end
    end
  end

  // response backpressure
  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      rsp_stall <= 1'b1;
    end else if (holds_done != hold_requests) begin
      holds_done++;
      stall_left = HOLD_CYCLES - 1;
      rsp_stall <= 1'b1;
    end else if (rst || recv_calm || $urandom_range(0, 3) != 0) begin
      rsp_stall <= 1'b0;
    end else begin
      stall_left = gap_len();
      rsp_stall <= 1'b1;
    end
  end

  // monitor, checker and watchdog
  always @(posedge clk) begin
    out_t due;
    if (!rst && req_valid && !req_stall) begin
      predict_route(req);
      routes_taken++;
    end
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected beat (%0d,%0d) last=%0b",
                                  rsp.point_x, rsp.point_y, rsp.last_point));
      end else begin
        due = pending_points.pop_front();
        if (rsp.point_x !== due.point_x) begin
          report_mismatch($sformatf("point_x got %0d exp %0d", rsp.point_x, due.point_x));
        end
        if (rsp.point_y !== due.point_y) begin
          report_mismatch($sformatf("point_y got %0d exp %0d", rsp.point_y, due.point_y));
        end
        if (rsp.last_point !== due.last_point) begin
          report_mismatch($sformatf("last_point got %0b exp %0b",
                                    rsp.last_point, due.last_point));
        end
      end
    end
    if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  initial begin
    int mark;
    repeat (6) @(negedge clk);
    rst <= 1'b0;

    // spare index must be ignored
    write_reg(REG_SPARE, cfg_t'($urandom));

    // reset config: shortest segment 10, loop 40 x 40
    add_route(0, 0, 0, 0, STYLE_STRAIGHT);
    add_route(CMIN, CMIN, CMAX, CMAX, STYLE_STRAIGHT);
    add_route(0, 0, 100, 50, STYLE_HV);
    add_route(0, 0, 100, 50, STYLE_VH);
    add_route(0, 0, 9, 50, STYLE_HV);
    add_route(0, 0, 10, 10, STYLE_HV);
    add_route(0, 0, 100, 50, STYLE_HVH);
    add_route(0, 0, 20, 10, STYLE_HVH);
    add_route(0, 0, 20, 11, STYLE_HVH);
    add_route(-101, 0, 0, 50, STYLE_HVH);
    add_route(0, 0, 50, 100, STYLE_VHV);
    add_route(0, 0, 5, 100, STYLE_VHV);
    add_route(0, -101, 50, 0, STYLE_VHV);
    add_route(0, 0, 10, 100, STYLE_HVH);
    add_route(0, 0, 100, 10, STYLE_VHV);
    add_route(0, 0, 5, 5, STYLE_HVH);
    add_route(100, 100, 100, 100, STYLE_HV);
    add_route(3, 3, 3, 3, STYLE_AUTO);
    add_route(3, 3, 40, -9, STYLE_AUTO);
    add_route(1, 2, 3, 4, STYLE_SPARE6);
    add_route(5, 5, 5, 5, STYLE_SPARE7);
    add_route(CMAX, CMAX, CMAX, CMAX, STYLE_AUTO);
    add_route(CMIN, CMIN, CMIN, CMIN, STYLE_HV);
    add_route(CMIN, 0, CMAX, 100, STYLE_HVH);
    drain();

    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: configure(12'd0, 12'd0, 12'd0);
        1: configure(12'd4095, 12'd4095, 12'd4095);
        2: configure(12'd1, 12'd1, 12'd3);
        3: configure(cfg_t'($urandom_range(0, 64)), cfg_t'($urandom), cfg_t'($urandom));
        4: configure(12'd10, 12'd40, 12'd40);
        5: configure(cfg_t'($urandom), cfg_t'($urandom), cfg_t'($urandom));
        default: configure(12'd2, 12'd4095, 12'd0);
      endcase
      send_calm = (p == 2 || p == 4) ? 1'b1 : 1'($urandom_range(0, 3) == 0);
      recv_calm = (p == 2) ? 1'b1 : 1'($urandom_range(0, 3) == 0);
      if (p == 0) begin
        // zero segment: every span test passes
        add_route(5, 5, 5, 5, STYLE_HV);
        add_route(5, 5, 5, 5, STYLE_HVH);
        add_route(7, 7, 7, 7, STYLE_AUTO);
      end
      mark = routes_taken + 10;
      for (int i = 0; i < PHASE_ROUTES; i++) begin
        add_random_route();
      end
      if (p == 4) begin
        // long receiver hold while requests keep coming
        while (routes_taken < mark) begin
          @(negedge clk);
        end
        hold_requests++;
      end
      drain();
    end

    repeat (SETTLE_CYCLES) @(negedge clk);
    if (mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
